// ===== src/cfap_pkg.sv =====
// Package for the crontab field atom parser.
// Holds the character codes, field limits, atom state and queue entry types.
// Used by cfap_front, cfap_queue, cfap_back and cron_field_atom_parser.
package cfap_pkg;

    // Characters that the parser recognizes.
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Field kinds.
    localparam logic [2:0] KIND_MINUTE = 3'd0;
    localparam logic [2:0] KIND_HOUR   = 3'd1;
    localparam logic [2:0] KIND_MDAY   = 3'd2;
    localparam logic [2:0] KIND_MONTH  = 3'd3;
    localparam logic [2:0] KIND_WDAY   = 3'd4;

    // Accumulators saturate at this value.
    localparam logic [11:0] ACC_MAX = 12'd255;

    // Range separator seen in the atom.
    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_DASH,
        SEP_TILDE
    } sep_t;

    // Running state of the atom being collected.
    typedef struct packed {
        logic [7:0] low_number;
        logic       low_present;
        logic [7:0] high_number;
        logic       high_present;
        logic [7:0] step_number;
        logic       step_active;
        logic       step_present;
        sep_t       separator;
        logic       lone_star;
        logic       malformed;
    } atom_t;

    // One closed atom travelling from the front to the back.
    typedef struct packed {
        atom_t      atom;
        logic [2:0] kind;
        logic       field_end;
        logic       closes;
    } qentry_t;

    // Limits of one field kind.
    typedef struct packed {
        logic       known;
        logic [5:0] min_value;
        logic [5:0] max_value;
    } limits_t;

    localparam atom_t ATOM_CLEAR = '{
        low_number:   8'd0,
        low_present:  1'b0,
        high_number:  8'd0,
        high_present: 1'b0,
        step_number:  8'd0,
        step_active:  1'b0,
        step_present: 1'b0,
        separator:    SEP_NONE,
        lone_star:    1'b0,
        malformed:    1'b0
    };

    // Lower and upper limit of each field kind; unknown kinds are flagged.
    function automatic limits_t field_limits(input logic [2:0] kind);
        limits_t lim;
        lim = '{known: 1'b0, min_value: 6'd0, max_value: 6'd0};
        case (kind)
            KIND_MINUTE: lim = '{known: 1'b1, min_value: 6'd0, max_value: 6'd59};
            KIND_HOUR:   lim = '{known: 1'b1, min_value: 6'd0, max_value: 6'd23};
            KIND_MDAY:   lim = '{known: 1'b1, min_value: 6'd1, max_value: 6'd31};
            KIND_MONTH:  lim = '{known: 1'b1, min_value: 6'd1, max_value: 6'd12};
            KIND_WDAY:   lim = '{known: 1'b1, min_value: 6'd0, max_value: 6'd7};
            default:     lim = '{known: 1'b0, min_value: 6'd0, max_value: 6'd0};
        endcase
        return lim;
    endfunction

    // One decimal digit into an accumulator, saturating.
    function automatic logic [7:0] acc_digit(input logic [7:0] value,
                                             input logic [3:0] digit);
        logic [11:0] sum;
        sum = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {8'd0, digit};
        return (sum > ACC_MAX) ? 8'hFF : sum[7:0];
    endfunction

endpackage

// ===== src/cron_field_atom_parser.sv =====
// Top level of the crontab field atom parser.
// Connects cfap_front, cfap_queue and cfap_back. Depends on cfap_pkg.
//
//   Port group   Direction  Carries
//   s_*          in         one field character per item, with kind and end flag
//   m_*          out        one range record per atom, or one error record
//
// One character item is taken every cycle while the atom queue has room.
// A record is registered when its atom leaves the queue; the atom
// queue (QUEUE_DEPTH entries) absorbs stalls on the result side.
// Reset (aresetn low at a clock edge) clears the atom state, queue and
// discard flag; the block is ready in the first cycle after reset.
module cron_field_atom_parser
    import cfap_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic [2:0] s_field_kind,
    input  logic       s_field_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_low_value,
    output logic [5:0] m_high_value,
    output logic [5:0] m_step_value,
    output logic       m_random_pick,
    output logic       m_atom_error,
    output logic       m_last_of_field
);

    logic    push_valid;
    logic    push_ready;
    qentry_t push_entry;
    logic    pop_valid;
    logic    pop_ready;
    qentry_t pop_entry;

    // Character classification and atom collection.
    cfap_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_field_kind(s_field_kind),
        .s_field_end (s_field_end),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    // Closed atoms waiting for evaluation.
    cfap_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_entry (push_entry),
        .out_valid(pop_valid),
        .out_ready(pop_ready),
        .out_entry(pop_entry)
    );

    // Limit checks and result records.
    cfap_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_low_value    (m_low_value),
        .m_high_value   (m_high_value),
        .m_step_value   (m_step_value),
        .m_random_pick  (m_random_pick),
        .m_atom_error   (m_atom_error),
        .m_last_of_field(m_last_of_field)
    );

endmodule

// ===== src/cfap_front.sv =====
// Front end of the parser: takes characters and builds the atom state.
// Pushes one queue entry each time an atom closes. Depends on cfap_pkg.
module cfap_front
    import cfap_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic [2:0] s_field_kind,
    input  logic       s_field_end,
    output logic       push_valid,
    input  logic       push_ready,
    output qentry_t    push_entry
);

    atom_t      atom_reg;
    atom_t      atom_next;
    logic       closes;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] digit_full;
    logic       accept;

    assign digit_full = s_char_code - CHAR_ZERO;
    assign digit      = digit_full[3:0];
    assign is_digit   = (s_char_code >= CHAR_ZERO) && (s_char_code <= CHAR_NINE);

    // Classify the character and update the atom state.
    always_comb begin
        atom_next = atom_reg;
        closes    = 1'b0;
        if (s_char_code == CHAR_COMMA) begin
            closes = 1'b1;
        end else if (atom_reg.step_active) begin
            if (is_digit) begin
                atom_next.step_number  = acc_digit(atom_reg.step_number, digit);
                atom_next.step_present = 1'b1;
            end else begin
                atom_next.malformed = 1'b1;
            end
        end else if (s_char_code == CHAR_SLASH) begin
            atom_next.step_active = 1'b1;
        end else if (is_digit) begin
            if (atom_reg.lone_star) begin
                atom_next.malformed = 1'b1;
            end else if (atom_reg.separator == SEP_NONE) begin
                atom_next.low_number  = acc_digit(atom_reg.low_number, digit);
                atom_next.low_present = 1'b1;
            end else begin
                atom_next.high_number  = acc_digit(atom_reg.high_number, digit);
                atom_next.high_present = 1'b1;
            end
        end else if ((s_char_code == CHAR_DASH) || (s_char_code == CHAR_TILDE)) begin
            if ((atom_reg.separator != SEP_NONE) || atom_reg.lone_star) begin
                atom_next.malformed = 1'b1;
            end else if (s_char_code == CHAR_DASH) begin
                atom_next.separator = SEP_DASH;
            end else begin
                atom_next.separator = SEP_TILDE;
            end
        end else if (s_char_code == CHAR_STAR) begin
            if (atom_reg.lone_star || (atom_reg.separator != SEP_NONE)
                    || atom_reg.low_present) begin
                atom_next.malformed = 1'b1;
            end else begin
                atom_next.lone_star = 1'b1;
            end
        end else begin
            atom_next.malformed = 1'b1;
        end
    end

    // A character is taken whenever the queue has room.
    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Closing an atom hands its state to the back end.
    assign push_valid            = s_valid && (closes || s_field_end);
    assign push_entry.atom       = atom_next;
    assign push_entry.kind       = s_field_kind;
    assign push_entry.field_end  = s_field_end;
    assign push_entry.closes     = closes;

    // Atom state register; cleared whenever an atom closes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atom_reg <= ATOM_CLEAR;
        end else if (accept) begin
            if (closes || s_field_end) begin
                atom_reg <= ATOM_CLEAR;
            end else begin
                atom_reg <= atom_next;
            end
        end
    end

endmodule

// ===== src/cfap_queue.sv =====
// Short queue of closed atoms between the front and back ends.
// Register array with read and write pointers. Depends on cfap_pkg.
module cfap_queue
    import cfap_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  qentry_t in_entry,
    output logic    out_valid,
    input  logic    out_ready,
    output qentry_t out_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qentry_t          entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_entry = entries_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ===== src/cfap_back.sv =====
// Back end of the parser: checks each closed atom against its field limits.
// Drives the registered result item and tracks discarding. Depends on cfap_pkg.
module cfap_back
    import cfap_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  qentry_t    pop_entry,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_low_value,
    output logic [5:0] m_high_value,
    output logic [5:0] m_step_value,
    output logic       m_random_pick,
    output logic       m_atom_error,
    output logic       m_last_of_field
);

    atom_t      atom;
    limits_t    lim;
    logic [7:0] min8;
    logic [7:0] max8;
    logic       ok;
    logic       is_error;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [5:0] st;
    logic       rnd;
    logic       take;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic       discard_reg;
    logic       discard_next;
    logic [5:0] low_reg;
    logic [5:0] high_reg;
    logic [5:0] step_reg;
    logic       random_reg;
    logic       error_reg;
    logic       last_reg;

    assign atom = pop_entry.atom;
    assign lim  = field_limits(pop_entry.kind);
    assign min8 = {2'b00, lim.min_value};
    assign max8 = {2'b00, lim.max_value};

    // Evaluate the atom at the head of the queue.
    always_comb begin
        ok  = lim.known && !atom.malformed;
        st  = 6'd1;
        rnd = 1'b0;
        lo  = 8'd0;
        hi  = 8'd0;
        if (atom.step_active) begin
            if (!atom.step_present || (atom.step_number < min8)
                    || (atom.step_number > max8)) begin
                ok = 1'b0;
            end
            st = atom.step_number[5:0];
        end
        if (atom.lone_star) begin
            lo = min8;
            hi = max8;
        end else if (atom.separator == SEP_NONE) begin
            if (!atom.low_present || (atom.low_number < min8)
                    || (atom.low_number > max8)) begin
                ok = 1'b0;
            end
            lo = atom.low_number;
            hi = atom.low_number;
        end else begin
            rnd = (atom.separator == SEP_TILDE);
            if (atom.low_present) begin
                if ((atom.low_number < min8) || (atom.low_number > max8)) begin
                    ok = 1'b0;
                end
                lo = atom.low_number;
            end else begin
                if (!rnd) begin
                    ok = 1'b0;
                end
                lo = min8;
            end
            if (atom.high_present) begin
                if ((atom.high_number < min8) || (atom.high_number > max8)) begin
                    ok = 1'b0;
                end
                hi = atom.high_number;
            end else begin
                if (!rnd) begin
                    ok = 1'b0;
                end
                hi = max8;
            end
            if (lo > hi) begin
                ok = 1'b0;
            end
        end
        is_error = !ok || (pop_entry.closes && pop_entry.field_end);
    end

    // Take an entry when the output register is free or being emptied.
    assign pop_ready = !m_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;

    // Output valid and discard tracking.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        discard_next = discard_reg;
        if (take) begin
            if (discard_reg) begin
                if (pop_entry.field_end) begin
                    discard_next = 1'b0;
                end
            end else begin
                m_valid_next = 1'b1;
                discard_next = is_error && !pop_entry.field_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            discard_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            discard_reg <= discard_next;
        end
    end

    // Result item payload; an error item carries zeros and is marked last.
    always_ff @(posedge aclk) begin
        if (take && !discard_reg) begin
            if (is_error) begin
                low_reg    <= 6'd0;
                high_reg   <= 6'd0;
                step_reg   <= 6'd0;
                random_reg <= 1'b0;
                error_reg  <= 1'b1;
                last_reg   <= 1'b1;
            end else begin
                low_reg    <= lo[5:0];
                high_reg   <= hi[5:0];
                step_reg   <= st;
                random_reg <= rnd;
                error_reg  <= 1'b0;
                last_reg   <= pop_entry.field_end;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_low_value     = low_reg;
    assign m_high_value    = high_reg;
    assign m_step_value    = step_reg;
    assign m_random_pick   = random_reg;
    assign m_atom_error    = error_reg;
    assign m_last_of_field = last_reg;

endmodule
